### src/sdspf_pkg.sv
// ============================================================================
// sdspf_pkg
// Shared types and constants for the sample dump data packet framer.
// ============================================================================
package sdspf_pkg;

    // Sample input width and clamping range of the sample width register
    localparam int unsigned SAMPLE_W = 28;
    localparam logic [4:0]  BITS_MIN = 5'd8;
    localparam logic [4:0]  BITS_MAX = 5'd28;
    localparam logic [4:0]  BITS_RST = 5'd16;

    // Data bytes carried by one packet
    localparam logic [6:0]  PKT_DATA_BYTES = 7'd120;

    // MIDI framing bytes
    localparam logic [7:0]  SYX_START = 8'hF0;
    localparam logic [6:0]  SYX_NONRT = 7'h7E;
    localparam logic [6:0]  SDS_DATA  = 7'h02;
    localparam logic [7:0]  SYX_END   = 8'hF7;

    // Configuration register indexes
    localparam logic CFG_IDX_SAMPLE_BITS = 1'b0;
    localparam logic CFG_IDX_DEVICE_ID   = 1'b1;

    // Header byte positions
    localparam logic [2:0] HDR_START  = 3'd0;
    localparam logic [2:0] HDR_NONRT  = 3'd1;
    localparam logic [2:0] HDR_DEVICE = 3'd2;
    localparam logic [2:0] HDR_SUBID  = 3'd3;
    localparam logic [2:0] HDR_PKTNUM = 3'd4;

    // Output sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_DATA,
        PH_PAD,
        PH_CHK,
        PH_END
    } phase_t;

endpackage

### src/sds_data_packet_framer.sv
// ============================================================================
// sds_data_packet_framer
// Frames raw samples into MIDI sample dump data packets, one byte run per beat.
// ============================================================================
// Usage:
//   s_ channel: one request per sample. s_tdata[27:0] is the raw sample
//   (low sample_bits bits used); s_tlast high means "close the dump": the
//   sample is ignored and the open packet is padded, checksummed and ended.
//   m_ channel: one request per MIDI byte run. m_tdata[7:0] is the byte,
//   m_tdata[14:8] its repeat count (above one only for zero padding),
//   m_tuser flags the closing F7 of a packet, m_tlast marks the final
//   request caused by one input request.
//   cfg port: index 0 = sample_bits, index 1 = device_id; write only while
//   the block is idle.
// Timing:
//   An accepted sample waits in the input register until the sequencer is
//   free, then its whole request list is computed in a single pass into
//   the sequencer registers. Output goes at one request per cycle while
//   m_tready is high. A sample gives 2..4 data bytes, plus 5 header bytes
//   at packet start or up to 3 close requests at packet end (at most 9);
//   a close request gives 2..3 requests, or none with no open packet (then
//   it just leaves the input register). The byte sequencer is the
//   bottleneck; the input register refills while the sequencer drains, so
//   the next sample is ready the cycle the last request of the current one
//   is taken.
// Reset: all packet state cleared, packet number 0, sample_bits 16,
//   device_id 0. A stalled receiver holds m_ stable; s_tready drops once the
//   input register is full.
// ============================================================================
module sds_data_packet_framer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [27:0] sample_value, [31:28] zero
    input  logic        s_tlast,    // last_sample

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [14:8] repeat_count, [15] zero
    output logic        m_tuser,    // packet_end
    output logic        m_tlast     // last
);

    // configuration
    logic [4:0] cfg_bits_reg;
    logic [6:0] cfg_dev_reg;

    // packet state
    logic [6:0] pkt_num_reg, pkt_num_next;
    logic [6:0] bip_reg,     bip_next;
    logic [6:0] csum_reg,    csum_next;

    // input register
    logic                          in_full_reg;
    logic [sdspf_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                          in_last_reg;

    // sequencer context
    sdspf_pkg::phase_t              phase_reg, phase_next;
    logic [2:0]                     idx_reg,   idx_next;
    logic [sdspf_pkg::SAMPLE_W-1:0] w_reg;
    logic [2:0]                     n_reg;
    logic                           close_reg;
    logic [6:0]                     pad_reg;
    logic [6:0]                     chk_reg;
    logic [6:0]                     dev_reg;
    logic [6:0]                     pn_reg;

    // single-pass item computation
    logic [4:0]                     bits_c;
    logic [2:0]                     m_c;
    logic [sdspf_pkg::SAMPLE_W-1:0] v_c, w_c;
    logic [6:0]                     room_c, bip_after_c, left_c;
    logic [2:0]                     n_c;
    logic                           hdr_c, close_c, has_res_c;
    logic [6:0]                     csum_start_c, csum_after_c;
    logic [6:0]                     b0_c, b1_c, b2_c, b3_c;
    sdspf_pkg::phase_t              after_data_c, first_c, after_data_r;

    // handshake
    logic in_pop, advance, cur_last, busy;

    // output byte fields
    logic [7:0] out_byte;
    logic [6:0] out_rep;
    logic       out_end;

    //--------------------------------------------------------------------
    // Configuration registers
    //--------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_bits_reg <= sdspf_pkg::BITS_RST;
            cfg_dev_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sdspf_pkg::CFG_IDX_SAMPLE_BITS: cfg_bits_reg <= cfg_wdata[4:0];
                sdspf_pkg::CFG_IDX_DEVICE_ID:   cfg_dev_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Handshake
    //--------------------------------------------------------------------
    assign busy     = (phase_reg != sdspf_pkg::PH_IDLE);
    assign advance  = busy && m_tready;
    assign in_pop   = in_full_reg && (!busy || (advance && cur_last));
    assign s_tready = !in_full_reg || in_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_full_reg <= 1'b1;
        end else if (in_pop) begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[sdspf_pkg::SAMPLE_W-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    //--------------------------------------------------------------------
    // Item computation: sample conversion, byte split, packet bookkeeping
    //--------------------------------------------------------------------
    always_comb begin
        priority if (cfg_bits_reg < sdspf_pkg::BITS_MIN) bits_c = sdspf_pkg::BITS_MIN;
        else if (cfg_bits_reg > sdspf_pkg::BITS_MAX)     bits_c = sdspf_pkg::BITS_MAX;
        else                                             bits_c = cfg_bits_reg;

        priority if (bits_c <= 5'd14) m_c = 3'd2;
        else if (bits_c <= 5'd21)     m_c = 3'd3;
        else                          m_c = 3'd4;

        // mask to width, flip MSB above 8 bits, left-justify into 28 bits
        v_c = in_sample_reg & ({sdspf_pkg::SAMPLE_W{1'b1}} >> (sdspf_pkg::BITS_MAX - bits_c));
        if (bits_c > sdspf_pkg::BITS_MIN)
            v_c = v_c ^ ({{(sdspf_pkg::SAMPLE_W-1){1'b0}}, 1'b1} << (bits_c - 5'd1));
        w_c = v_c << (sdspf_pkg::BITS_MAX - bits_c);

        b0_c = w_c[27:21];
        b1_c = w_c[20:14];
        b2_c = w_c[13:7];
        b3_c = w_c[6:0];

        hdr_c  = !in_last_reg && (bip_reg == '0);
        room_c = sdspf_pkg::PKT_DATA_BYTES - bip_reg;
        if (in_last_reg)
            n_c = '0;
        else if ({4'b0, m_c} < room_c)
            n_c = m_c;
        else
            n_c = room_c[2:0];

        bip_after_c = bip_reg + {4'b0, n_c};
        left_c      = sdspf_pkg::PKT_DATA_BYTES - bip_after_c;

        csum_start_c = hdr_c ? (sdspf_pkg::SYX_NONRT ^ cfg_dev_reg ^ sdspf_pkg::SDS_DATA
                                ^ pkt_num_reg)
                             : csum_reg;
        csum_after_c = csum_start_c
                     ^ ((n_c > 3'd0) ? b0_c : 7'd0)
                     ^ ((n_c > 3'd1) ? b1_c : 7'd0)
                     ^ ((n_c > 3'd2) ? b2_c : 7'd0)
                     ^ ((n_c > 3'd3) ? b3_c : 7'd0);

        has_res_c = !in_last_reg || (bip_reg != '0);
        close_c   = in_last_reg ? (bip_reg != '0) : (left_c < {4'b0, m_c});

        // phase order for the freshly computed item
        if (close_c)
            after_data_c = (left_c != '0) ? sdspf_pkg::PH_PAD : sdspf_pkg::PH_CHK;
        else
            after_data_c = sdspf_pkg::PH_IDLE;
        if (!has_res_c)
            first_c = sdspf_pkg::PH_IDLE;
        else if (hdr_c)
            first_c = sdspf_pkg::PH_HDR;
        else if (n_c != '0)
            first_c = sdspf_pkg::PH_DATA;
        else
            first_c = after_data_c;
    end

    // packet state update at the moment an item enters the sequencer
    always_comb begin
        pkt_num_next = pkt_num_reg;
        bip_next     = bip_reg;
        csum_next    = csum_reg;
        if (in_pop) begin
            if (close_c) begin
                pkt_num_next = pkt_num_reg + 7'd1;
                bip_next     = '0;
                csum_next    = '0;
            end else if (!in_last_reg) begin
                bip_next  = bip_after_c;
                csum_next = csum_after_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_num_reg <= '0;
            bip_reg     <= '0;
            csum_reg    <= '0;
        end else begin
            pkt_num_reg <= pkt_num_next;
            bip_reg     <= bip_next;
            csum_reg    <= csum_next;
        end
    end

    // item context, held while its requests drain
    always_ff @(posedge aclk) begin
        if (in_pop) begin
            w_reg     <= w_c;
            n_reg     <= n_c;
            close_reg <= close_c;
            pad_reg   <= left_c;
            chk_reg   <= csum_after_c;
            dev_reg   <= cfg_dev_reg;
            pn_reg    <= pkt_num_reg;
        end
    end

    //--------------------------------------------------------------------
    // Output sequencer: next phase
    //--------------------------------------------------------------------
    always_comb begin
        if (close_reg)
            after_data_r = (pad_reg != '0) ? sdspf_pkg::PH_PAD : sdspf_pkg::PH_CHK;
        else
            after_data_r = sdspf_pkg::PH_IDLE;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (in_pop) begin
            phase_next = first_c;
            idx_next   = '0;
        end else if (advance) begin
            unique case (phase_reg)
                sdspf_pkg::PH_HDR: begin
                    if (idx_reg == sdspf_pkg::HDR_PKTNUM) begin
                        phase_next = (n_reg != '0) ? sdspf_pkg::PH_DATA : after_data_r;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                sdspf_pkg::PH_DATA: begin
                    if (idx_reg == n_reg - 3'd1) begin
                        phase_next = after_data_r;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                sdspf_pkg::PH_PAD:  phase_next = sdspf_pkg::PH_CHK;
                sdspf_pkg::PH_CHK:  phase_next = sdspf_pkg::PH_END;
                sdspf_pkg::PH_END:  phase_next = sdspf_pkg::PH_IDLE;
                default:            phase_next = sdspf_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sdspf_pkg::PH_IDLE;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    //--------------------------------------------------------------------
    // Output sequencer: current request
    //--------------------------------------------------------------------
    always_comb begin
        out_byte = '0;
        out_rep  = 7'd1;
        out_end  = 1'b0;
        cur_last = 1'b0;
        unique case (phase_reg)
            sdspf_pkg::PH_HDR: begin
                unique case (idx_reg)
                    sdspf_pkg::HDR_START:  out_byte = sdspf_pkg::SYX_START;
                    sdspf_pkg::HDR_NONRT:  out_byte = {1'b0, sdspf_pkg::SYX_NONRT};
                    sdspf_pkg::HDR_DEVICE: out_byte = {1'b0, dev_reg};
                    sdspf_pkg::HDR_SUBID:  out_byte = {1'b0, sdspf_pkg::SDS_DATA};
                    sdspf_pkg::HDR_PKTNUM: out_byte = {1'b0, pn_reg};
                    default:               out_byte = '0;
                endcase
            end
            sdspf_pkg::PH_DATA: begin
                unique case (idx_reg[1:0])
                    2'd0: out_byte = {1'b0, w_reg[27:21]};
                    2'd1: out_byte = {1'b0, w_reg[20:14]};
                    2'd2: out_byte = {1'b0, w_reg[13:7]};
                    2'd3: out_byte = {1'b0, w_reg[6:0]};
                    default: out_byte = '0;
                endcase
                cur_last = !close_reg && (idx_reg == n_reg - 3'd1);
            end
            sdspf_pkg::PH_PAD: out_rep  = pad_reg;
            sdspf_pkg::PH_CHK: out_byte = {1'b0, chk_reg};
            sdspf_pkg::PH_END: begin
                out_byte = sdspf_pkg::SYX_END;
                out_end  = 1'b1;
                cur_last = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = busy;
    assign m_tdata  = {1'b0, out_rep, out_byte};
    assign m_tuser  = out_end;
    assign m_tlast  = cur_last;

endmodule
